### rtl/wtn_pkg.sv
// Shared types, character constants and byte helpers for the web text normaliser.
// No dependencies; imported by every module of the block.
package wtn_pkg;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] ACC_LO   = 8'd192;
  localparam logic [7:0] ACC_HI   = 8'd221;
  localparam logic [7:0] CASE_OFS = 8'd32;

  localparam int MAX_RES = 3;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_KEEP_CASE      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DECODE_ESCAPES = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STRIP_TAGS     = 2'd2;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] chars;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } wtn_entry_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eod;
  } wtn_result_t;

  function automatic logic [7:0] stage_one(input logic [7:0] c, input logic keep);
    logic [7:0] r;
    r = c;
    if (!keep && (((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= ACC_LO) && (c <= ACC_HI)))) begin
      r = c + CASE_OFS;
    end else if ((c == CH_CR) || (c == CH_TAB) || (c == CH_LF)) begin
      r = CH_SPACE;
    end
    return r;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= CH_LC_A) && (c <= CH_LC_F));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return (c <= CH_NINE) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

endpackage

### rtl/web_text_normalizer_core.sv
// Web text normaliser top level: configuration registers, front end, queue, back end.
// Depends on wtn_pkg, wtn_front, wtn_queue and wtn_back.
//
// Input channel: drive in_byte and last_byte with push; a beat is taken at a
// rising edge with push high and full low. Result channel: while empty is low
// out_byte, byte_valid and end_of_document show the oldest result; raise pop
// to take it. Each document byte gives zero to three results; the final byte
// of a document always gives at least one, the last carrying end_of_document
// (a bare marker with byte_valid low when nothing else is left).
// Configuration: cfg_we writes cfg_data into register cfg_index (0 keep_case,
// 1 decode_escapes, 2 strip_tags) at the clock edge; write only while idle.
// With the back end idle, the first result of a byte is written into the queue
// and then loaded into the result buffer, both registered, before it shows.
// Throughput: one input beat per cycle while bytes give at most one result
// each and pop stays high; the back end's result buffer drains one result per
// cycle, so a byte giving k results holds the back end until all k are popped,
// and the four-entry queue absorbs the burst before full rises.
// Reset: rst clears the queue and the result buffer, the escape and tag state,
// and loads the register defaults. A stalled receiver fills the result buffer,
// then the queue, then raises full; nothing is dropped.
module web_text_normalizer_core import wtn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_byte,
  input  logic                 last_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           out_byte,
  output logic                 byte_valid,
  output logic                 end_of_document,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  logic        keep_case;
  logic        decode_escapes;
  logic        strip_tags;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  wtn_entry_t  q_wr;
  wtn_entry_t  q_rd;
  wtn_result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_case      <= 1'b0;
      decode_escapes <= 1'b0;
      strip_tags     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEEP_CASE:      keep_case      <= cfg_data;
        REG_DECODE_ESCAPES: decode_escapes <= cfg_data;
        REG_STRIP_TAGS:     strip_tags     <= cfg_data;
        default: ;
      endcase
    end
  end

  wtn_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .in_byte        (in_byte),
    .last_byte      (last_byte),
    .keep_case      (keep_case),
    .decode_escapes (decode_escapes),
    .strip_tags     (strip_tags),
    .q_full         (full),
    .q_push         (q_push),
    .q_entry        (q_wr)
  );

  wtn_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  wtn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .strip_tags (strip_tags),
    .q_empty    (q_empty),
    .q_data     (q_rd),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

  assign out_byte        = result.data;
  assign byte_valid      = result.valid;
  assign end_of_document = result.eod;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && q_empty))
    else $error("result side not empty after reset");

  a_bare_is_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (end_of_document && (out_byte == 8'd0)))
    else $error("bare result without end marker or with data");

  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    (push && !full && last_byte) |-> q_push)
    else $error("final byte of a document queued nothing");
`endif

endmodule

### rtl/wtn_front.sv
// Front end: case folding, whitespace mapping, percent-escape decoding and document-start space.
// Emits at most one queue entry of up to three candidate bytes per accepted byte; uses wtn_pkg.
module wtn_front import wtn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  input  logic       keep_case,
  input  logic       decode_escapes,
  input  logic       strip_tags,
  input  logic       q_full,
  output logic       q_push,
  output wtn_entry_t q_entry
);

  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic [7:0] held_char;
  logic [7:0] held_char_next;
  logic       doc_start;
  logic       accept;
  logic [7:0] s;
  wtn_entry_t e;

  function automatic wtn_entry_t add_char(input wtn_entry_t x, input logic [7:0] c);
    wtn_entry_t y;
    y = x;
    if (x.count < CNT_W'(MAX_RES)) begin
      y.chars[x.count[1:0]] = c;
      y.count = x.count + 1'b1;
    end
    return y;
  endfunction

  assign accept = push && !q_full;
  assign s      = stage_one(in_byte, keep_case);

  always_comb begin
    e = '0;
    e.last = last_byte;
    held_count_next = held_count;
    held_char_next  = held_char;
    if (doc_start && strip_tags) begin
      e = add_char(e, CH_SPACE);
    end
    if (!decode_escapes) begin
      if (held_count != 2'd0) e = add_char(e, CH_PCT);
      if (held_count == 2'd2) e = add_char(e, held_char);
      e = add_char(e, s);
      held_count_next = 2'd0;
    end else begin
      case (held_count)
        2'd0: begin
          if (s == CH_PCT) held_count_next = 2'd1;
          else e = add_char(e, s);
        end
        2'd1: begin
          if (is_hex(s)) begin
            held_char_next  = s;
            held_count_next = 2'd2;
          end else begin
            e = add_char(e, CH_PCT);
            if (s == CH_PCT) begin
              held_count_next = 2'd1;
            end else begin
              e = add_char(e, s);
              held_count_next = 2'd0;
            end
          end
        end
        default: begin
          if (is_hex(s)) begin
            e = add_char(e, {hex_val(held_char), hex_val(s)});
            held_count_next = 2'd0;
          end else begin
            e = add_char(e, CH_PCT);
            e = add_char(e, held_char);
            if (s == CH_PCT) begin
              held_count_next = 2'd1;
            end else begin
              e = add_char(e, s);
              held_count_next = 2'd0;
            end
          end
        end
      endcase
    end
    if (last_byte) begin
      if (held_count_next != 2'd0) e = add_char(e, CH_PCT);
      if (held_count_next == 2'd2) e = add_char(e, held_char_next);
      held_count_next = 2'd0;
    end
  end

  assign q_push  = accept && ((e.count != '0) || last_byte);
  assign q_entry = e;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      doc_start  <= 1'b1;
    end else if (accept) begin
      held_count <= held_count_next;
      doc_start  <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_char <= held_char_next;
    end
  end

endmodule

### rtl/wtn_queue.sv
// Short entry queue between the front and back ends.
// Register-based, one write and one read port; uses wtn_pkg.
module wtn_queue import wtn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  wtn_entry_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output wtn_entry_t rd_data,
  output logic       empty
);

  wtn_entry_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### rtl/wtn_back.sv
// Back end: tag stripping, space collapsing and end-of-document marking.
// Drains queue entries into a small result buffer popped one beat at a time; uses wtn_pkg.
module wtn_back import wtn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        strip_tags,
  input  logic        q_empty,
  input  wtn_entry_t  q_data,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output wtn_result_t result
);

  wtn_result_t      res [MAX_RES];
  wtn_result_t      rb  [MAX_RES];
  logic [CNT_W-1:0] res_count;
  logic [CNT_W-1:0] rn;
  logic             inside_tag;
  logic             prev_was_space;
  logic             inside_next;
  logic             prev_next;
  logic             take;
  logic             shift;

  always_comb begin
    logic [7:0] b;
    logic       keep;
    for (int k = 0; k < MAX_RES; k++) rb[k] = '0;
    rn          = '0;
    inside_next = inside_tag;
    prev_next   = prev_was_space;
    for (int k = 0; k < MAX_RES; k++) begin
      b    = q_data.chars[k];
      keep = 1'b0;
      if (CNT_W'(k) < q_data.count) begin
        if (!strip_tags) begin
          keep = 1'b1;
        end else begin
          if (b == CH_LT) inside_next = 1'b1;
          if (b == CH_GT) begin
            inside_next = 1'b0;
            b = CH_SPACE;
          end
          if (!inside_next && !((b == CH_SPACE) && prev_next)) begin
            keep      = 1'b1;
            prev_next = (b == CH_SPACE);
          end
        end
      end
      if (keep) begin
        rb[rn[1:0]] = '{data: b, valid: 1'b1, eod: 1'b0};
        rn = rn + 1'b1;
      end
    end
    if (q_data.last) begin
      if (rn == '0) begin
        rb[0] = '{data: 8'd0, valid: 1'b0, eod: 1'b0};
        rn = CNT_W'(1);
      end
      rb[2'(rn - 1'b1)].eod = 1'b1;
      inside_next = 1'b0;
      prev_next   = 1'b0;
    end
  end

  assign empty  = (res_count == '0);
  assign result = res[0];
  assign take   = !q_empty && ((res_count == '0) || ((res_count == CNT_W'(1)) && pop));
  assign shift  = pop && !empty;
  assign q_pop  = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_count      <= '0;
      inside_tag     <= 1'b0;
      prev_was_space <= 1'b0;
    end else if (take) begin
      res_count      <= rn;
      inside_tag     <= inside_next;
      prev_was_space <= prev_next;
    end else if (shift) begin
      res_count <= res_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= rb;
    end else if (shift) begin
      for (int k = 0; k < MAX_RES - 1; k++) res[k] <= res[k+1];
    end
  end

endmodule
